// ===== sv/lcpc_pkg.sv =====
// shared types and constants of the lcp local minimum clusterer
package lcpc_pkg;

  localparam int unsigned LCP_BITS     = 16;
  localparam int unsigned INDEX_BITS   = 32;
  localparam int unsigned LEN_BITS     = 16;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 4;

  localparam int unsigned OQ_DEPTH     = 4;
  localparam int unsigned OQ_PTR_BITS  = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_BITS  = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LCP    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LENGTH = CFG_IDX_BITS'(1);

  localparam logic [CFG_BITS-1:0] MIN_LCP_RESET    = CFG_BITS'(16);
  localparam logic [CFG_BITS-1:0] MIN_LENGTH_RESET = CFG_BITS'(2);

  typedef struct packed {
    logic [LCP_BITS-1:0] lcp_value;
    logic                stream_end;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] cluster_start;
    logic [LEN_BITS-1:0]   cluster_length;
    logic                  run_last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] min_lcp;
    logic [CFG_BITS-1:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

endpackage

// ===== sv/lcpc_if.sv =====
// request channel interfaces of the lcp local minimum clusterer
interface lcpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [lcpc_pkg::LCP_BITS-1:0] lcp_value;
  logic                          stream_end;

  modport source (output valid, output lcp_value, output stream_end, input ready);
  modport sink (input valid, input lcp_value, input stream_end, output ready);
endinterface

interface lcpc_out_if;
  logic                            valid;
  logic                            ready;
  logic [lcpc_pkg::INDEX_BITS-1:0] cluster_start;
  logic [lcpc_pkg::LEN_BITS-1:0]   cluster_length;
  logic                            run_last;

  modport source (output valid, output cluster_start, output cluster_length,
                  output run_last, input ready);
  modport sink (input valid, input cluster_start, input cluster_length,
                input run_last, output ready);
endinterface

interface lcpc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lcpc_pkg::CFG_IDX_BITS-1:0] index;
  logic [lcpc_pkg::CFG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/lcpc_core.sv =====
// input register, lcp window state and cluster close and flush logic
module lcpc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcpc_in_if.sink           in_i,
  input  lcpc_pkg::cfg_t    cfg_i,
  input  logic              space_i,
  output lcpc_pkg::push_t   push_o
);

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_FULL  = 2'd2;

  logic                              item_vld_q;
  lcpc_pkg::in_item_t                item_q;
  logic [1:0]                        fill_q;
  logic                              open_q;
  logic [lcpc_pkg::LCP_BITS-1:0]     older_q;
  logic [lcpc_pkg::LCP_BITS-1:0]     middle_q;
  logic [lcpc_pkg::INDEX_BITS-1:0]   start_q;
  logic [lcpc_pkg::INDEX_BITS-1:0]   pos_q;

  logic                              fire;
  logic [lcpc_pkg::LCP_BITS-1:0]     v;
  logic                              close;
  logic                              keep;
  logic                              open_d;
  logic [lcpc_pkg::INDEX_BITS-1:0]   pos_d;
  logic [lcpc_pkg::INDEX_BITS-1:0]   start_d;
  logic [lcpc_pkg::LCP_BITS-1:0]     older_d;
  logic [1:0]                        fill_d;
  logic [lcpc_pkg::INDEX_BITS-1:0]   diff1;
  logic [lcpc_pkg::INDEX_BITS-1:0]   diff2;
  logic                              emit1;
  logic                              emit2;
  lcpc_pkg::out_item_t               res1;
  lcpc_pkg::out_item_t               res2;

  assign fire       = item_vld_q && space_i;
  assign in_i.ready = !item_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.lcp_value  <= in_i.lcp_value;
      item_q.stream_end <= in_i.stream_end;
    end
  end

  // window decisions
  always_comb begin
    v     = item_q.lcp_value;
    close = fill_q[1] && open_q &&
            (((older_q > middle_q) && (middle_q <= v)) || (v < cfg_i.min_lcp));
    case (fill_q)
      FILL_EMPTY: begin
        pos_d   = '0;
        older_d = older_q;
        fill_d  = FILL_ONE;
      end
      FILL_ONE: begin
        pos_d   = lcpc_pkg::INDEX_BITS'(1);
        older_d = middle_q;
        fill_d  = FILL_FULL;
      end
      default: begin
        pos_d   = pos_q + lcpc_pkg::INDEX_BITS'(1);
        older_d = middle_q;
        fill_d  = FILL_FULL;
      end
    endcase
    keep    = open_q && !close;
    open_d  = keep || (v >= cfg_i.min_lcp);
    start_d = keep ? start_q : pos_d;
    diff1   = pos_q - start_q + lcpc_pkg::INDEX_BITS'(1);
    diff2   = pos_d - start_d + lcpc_pkg::INDEX_BITS'(1);
    emit1   = close && (diff1[lcpc_pkg::LEN_BITS-1:0] >= cfg_i.min_length);
    emit2   = item_q.stream_end && open_d &&
              (diff2[lcpc_pkg::LEN_BITS-1:0] >= cfg_i.min_length);

    res1.cluster_start  = start_q;
    res1.cluster_length = diff1[lcpc_pkg::LEN_BITS-1:0];
    res1.run_last       = !emit2;
    res2.cluster_start  = start_d;
    res2.cluster_length = diff2[lcpc_pkg::LEN_BITS-1:0];
    res2.run_last       = 1'b1;

    push_o.r0  = emit1 ? res1 : res2;
    push_o.r1  = res2;
    push_o.cnt = 2'd0;
    if (fire) begin
      push_o.cnt = {1'b0, emit1} + {1'b0, emit2};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= FILL_EMPTY;
      open_q   <= 1'b0;
      older_q  <= '0;
      middle_q <= '0;
      start_q  <= '0;
      pos_q    <= '0;
    end else if (fire) begin
      if (item_q.stream_end) begin
        fill_q   <= FILL_EMPTY;
        open_q   <= 1'b0;
        older_q  <= '0;
        middle_q <= '0;
        start_q  <= '0;
        pos_q    <= '0;
      end else begin
        fill_q   <= fill_d;
        open_q   <= open_d;
        older_q  <= older_d;
        middle_q <= v;
        start_q  <= start_d;
        pos_q    <= pos_d;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_q.stream_end |=> (fill_q == FILL_EMPTY) && !open_q)
    else $error("stream end did not clear window state");

  a_push_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt != 2'd0) |-> fire && (push_o.cnt != 2'd3))
    else $error("results pushed without an item in work");

  a_fill_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !item_q.stream_end && (fill_q == FILL_EMPTY) |=>
      (fill_q == FILL_ONE) && (pos_q == '0))
    else $error("first item did not enter the window at position zero");

endmodule

// ===== sv/lcpc_fifo.sv =====
// result queue that takes up to two results per cycle and hands out one while ready
module lcpc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcpc_pkg::push_t  push_i,
  output logic             space_o,
  lcpc_out_if.source       out_o
);

  lcpc_pkg::out_item_t                 mem_q [lcpc_pkg::OQ_DEPTH];
  logic [lcpc_pkg::OQ_PTR_BITS-1:0]    wr_ptr_q;
  logic [lcpc_pkg::OQ_PTR_BITS-1:0]    rd_ptr_q;
  logic [lcpc_pkg::OQ_CNT_BITS-1:0]    cnt_q;
  logic [lcpc_pkg::OQ_PTR_BITS-1:0]    wr_ptr_nx;
  logic                                pop;
  lcpc_pkg::out_item_t                 head;

  assign space_o   = cnt_q <= lcpc_pkg::OQ_CNT_BITS'(lcpc_pkg::OQ_DEPTH - 2);
  assign pop       = out_o.valid && out_o.ready;
  assign wr_ptr_nx = wr_ptr_q + lcpc_pkg::OQ_PTR_BITS'(1);
  assign head      = mem_q[rd_ptr_q];

  assign out_o.valid          = cnt_q != '0;
  assign out_o.cluster_start  = head.cluster_start;
  assign out_o.cluster_length = head.cluster_length;
  assign out_o.run_last       = head.run_last;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + lcpc_pkg::OQ_PTR_BITS'(push_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + lcpc_pkg::OQ_PTR_BITS'(1);
      end
      cnt_q <= cnt_q + lcpc_pkg::OQ_CNT_BITS'(push_i.cnt) - lcpc_pkg::OQ_CNT_BITS'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lcpc_pkg::OQ_CNT_BITS'(lcpc_pkg::OQ_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> space_o)
    else $error("results pushed into a full queue");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (push_i.cnt == 2'd0) |=> cnt_q == $past(cnt_q) - lcpc_pkg::OQ_CNT_BITS'(1))
    else $error("queue count lost track of a pop");

endmodule

// ===== sv/lcp_local_minimum_clusterer.sv =====
// top level of the lcp local minimum clusterer
//
//   channel  dir  carries                                  request when
//   cfg_i    in   index, data (min_lcp, min_length)        valid & ready
//   in_i     in   lcp_value, stream_end                    valid & ready
//   out_o    out  cluster_start, cluster_length, run_last  valid & ready
//
// one item per cycle enters the input register while it is free or being emptied;
// it is decided there once the queue has room; results land in a four-entry queue
// an item is held while the queue has fewer than two free entries; the output port
// pops one result per cycle while out_o.ready is high; two results leave in turn
// cfg_i is always ready; reset sets min_lcp to 16, min_length to 2, window empty
module lcp_local_minimum_clusterer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcpc_cfg_if.sink   cfg_i,
  lcpc_in_if.sink    in_i,
  lcpc_out_if.source out_o
);

  logic [lcpc_pkg::CFG_BITS-1:0] min_lcp_q;
  logic [lcpc_pkg::CFG_BITS-1:0] min_length_q;
  lcpc_pkg::cfg_t                cfg;
  lcpc_pkg::push_t               push;
  logic                          space;

  assign cfg_i.ready    = 1'b1;
  assign cfg.min_lcp    = min_lcp_q;
  assign cfg.min_length = min_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lcp_q    <= lcpc_pkg::MIN_LCP_RESET;
      min_length_q <= lcpc_pkg::MIN_LENGTH_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lcpc_pkg::CFG_MIN_LCP:    min_lcp_q    <= cfg_i.data;
        lcpc_pkg::CFG_MIN_LENGTH: min_length_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  lcpc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .space_i (space),
    .push_o  (push)
  );

  lcpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

// ===== test/tb_lcp_local_minimum_clusterer.sv =====
// testbench of the lcp local minimum clusterer with a cluster predictor and scoreboard
`timescale 1ns / 1ps

class cluster_tracker;
  logic [lcpc_pkg::CFG_BITS-1:0]   min_lcp;
  logic [lcpc_pkg::CFG_BITS-1:0]   min_length;
  logic [lcpc_pkg::LCP_BITS-1:0]   older_lcp;
  logic [lcpc_pkg::LCP_BITS-1:0]   middle_lcp;
  logic                            cluster_open;
  logic [lcpc_pkg::INDEX_BITS-1:0] open_start;
  logic [lcpc_pkg::INDEX_BITS-1:0] middle_pos;
  logic [1:0]                      window_fill;
  lcpc_pkg::out_item_t             pending_clusters[$];
  lcpc_pkg::out_item_t             fresh[$];
  int unsigned errors;
  int unsigned requests;
  int unsigned streams;
  int unsigned emitted;
  int unsigned dropped;
  int unsigned doubles;
  int unsigned checked;

  function new();
    min_lcp    = lcpc_pkg::MIN_LCP_RESET;
    min_length = lcpc_pkg::MIN_LENGTH_RESET;
    clear_stream();
  endfunction

  function void clear_stream();
    older_lcp    = '0;
    middle_lcp   = '0;
    cluster_open = 1'b0;
    open_start   = '0;
    middle_pos   = '0;
    window_fill  = 2'd0;
  endfunction

  function void set_reg(logic [lcpc_pkg::CFG_IDX_BITS-1:0] index,
                        logic [lcpc_pkg::CFG_BITS-1:0] data);
    if (index == lcpc_pkg::CFG_MIN_LCP) begin
      min_lcp = data;
    end else if (index == lcpc_pkg::CFG_MIN_LENGTH) begin
      min_length = data;
    end
  endfunction

  function int pending();
    return pending_clusters.size();
  endfunction

  function void close_at(logic [lcpc_pkg::INDEX_BITS-1:0] end_pos);
    lcpc_pkg::out_item_t item;
    logic [lcpc_pkg::INDEX_BITS-1:0] span;
    span = end_pos - open_start + 1;
    item.cluster_start  = open_start;
    item.cluster_length = span[lcpc_pkg::LEN_BITS-1:0];
    item.run_last       = 1'b0;
    if (item.cluster_length < min_length) begin
      dropped++;
    end else begin
      fresh.push_back(item);
    end
  endfunction

  function void note_request(logic [lcpc_pkg::LCP_BITS-1:0] lcp, logic last);
    requests++;
    fresh.delete();
    if (window_fill == 2'd0) begin
      middle_lcp  = lcp;
      middle_pos  = '0;
      window_fill = 2'd1;
    end else if (window_fill == 2'd1) begin
      older_lcp   = middle_lcp;
      middle_lcp  = lcp;
      middle_pos  = 1;
      window_fill = 2'd2;
    end else begin
      if (cluster_open &&
          ((older_lcp > middle_lcp && middle_lcp <= lcp) || lcp < min_lcp)) begin
        close_at(middle_pos);
        cluster_open = 1'b0;
      end
      older_lcp   = middle_lcp;
      middle_lcp  = lcp;
      middle_pos  = middle_pos + 1;
      window_fill = 2'd2;
    end
    if (!cluster_open && lcp >= min_lcp) begin
      cluster_open = 1'b1;
      open_start   = middle_pos;
    end
    if (last) begin
      if (cluster_open) close_at(middle_pos);
      clear_stream();
      streams++;
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].run_last = 1'b1;
    if (fresh.size() == 2) doubles++;
    foreach (fresh[i]) pending_clusters.push_back(fresh[i]);
    emitted += fresh.size();
  endfunction

  task flag_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  task check_cluster(lcpc_pkg::out_item_t got);
    lcpc_pkg::out_item_t want;
    if (pending_clusters.size() == 0) begin
      flag_mismatch($sformatf("unexpected cluster start %0d length %0d",
                              got.cluster_start, got.cluster_length));
      return;
    end
    want = pending_clusters.pop_front();
    checked++;
    if (got.cluster_start !== want.cluster_start)
      flag_mismatch($sformatf("cluster_start %0d, want %0d",
                              got.cluster_start, want.cluster_start));
    if (got.cluster_length !== want.cluster_length)
      flag_mismatch($sformatf("cluster_length %0d, want %0d (start %0d)",
                              got.cluster_length, want.cluster_length, want.cluster_start));
    if (got.run_last !== want.run_last)
      flag_mismatch($sformatf("run_last %0b, want %0b (start %0d)",
                              got.run_last, want.run_last, want.cluster_start));
  endtask
endclass

module tb_lcp_local_minimum_clusterer;

  localparam int unsigned HANG_LIMIT   = 2000;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned PHASE_ITEMS  = 234;

  logic clk_i;
  logic rst_ni;

  lcpc_cfg_if cfg_if ();
  lcpc_in_if  in_if ();
  lcpc_out_if out_if ();

  cluster_tracker tracker;

  logic                          idle_on;
  logic                          hold_long;
  logic [lcpc_pkg::LCP_BITS-1:0] lcp_walk;
  int unsigned                   hang_cycles;
  int unsigned                   settings;

  lcp_local_minimum_clusterer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    idle_on          = 1'b1;
    hold_long        = 1'b0;
    lcp_walk         = '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    in_if.valid      <= 1'b0;
    in_if.lcp_value  <= '0;
    in_if.stream_end <= 1'b0;
    out_if.ready     <= 1'b0;
  end

  // result sampling and hang detection
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        tracker.check_cluster({out_if.cluster_start, out_if.cluster_length,
                               out_if.run_last});
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        hang_cycles <= 0;
      end else begin
        hang_cycles <= hang_cycles + 1;
      end
      if (hang_cycles >= HANG_LIMIT) begin
        $display("timeout after %0d cycles without a request", hang_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end else begin
      hang_cycles <= 0;
    end
  end

  // receiver side stalls
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [lcpc_pkg::LCP_BITS-1:0] next_lcp();
    int t;
    case ($urandom_range(0, 9))
      0: t = 0;
      1: t = 65535;
      2, 3: t = $urandom_range(0, 65535);
      4, 5, 6: t = int'(lcp_walk) + int'($urandom_range(0, 6)) - 3;
      default: t = int'(tracker.min_lcp) + int'($urandom_range(0, 8)) - 4;
    endcase
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    lcp_walk = lcpc_pkg::LCP_BITS'(t);
    return lcp_walk;
  endfunction

  task automatic drive_item(logic [lcpc_pkg::LCP_BITS-1:0] lcp, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.lcp_value  <= lcp;
    in_if.stream_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_request(lcp, last);
  endtask

  task automatic write_thresholds(logic [lcpc_pkg::CFG_BITS-1:0] lcp_floor,
                                  logic [lcpc_pkg::CFG_BITS-1:0] length_floor);
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= lcpc_pkg::CFG_MIN_LCP;
    cfg_if.data  <= lcp_floor;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_reg(lcpc_pkg::CFG_MIN_LCP, lcp_floor);
    cfg_if.index <= lcpc_pkg::CFG_MIN_LENGTH;
    cfg_if.data  <= length_floor;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_reg(lcpc_pkg::CFG_MIN_LENGTH, length_floor);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  task automatic run_streams(int unsigned count);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      if (sent + len > count) len = count - sent;
      for (int unsigned i = 0; i < len; i++) begin
        drive_item(next_lcp(), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    tracker     = new();
    settings    = 0;
    hang_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: min_lcp 16, min_length 2
    drive_item(16'd20, 1'b1);
    drive_item(16'd16, 1'b0);
    drive_item(16'd17, 1'b1);
    drive_item(16'hFFFF, 1'b0);
    drive_item(16'd40, 1'b0);
    drive_item(16'd10, 1'b0);
    drive_item(16'd50, 1'b0);
    drive_item(16'd50, 1'b0);
    drive_item(16'd3, 1'b0);
    drive_item(16'd0, 1'b1);
    drive_item(16'd30, 1'b0);
    drive_item(16'd20, 1'b0);
    drive_item(16'd18, 1'b0);
    drive_item(16'd25, 1'b0);
    drive_item(16'd25, 1'b0);
    drive_item(16'd0, 1'b1);

    // close and flush from the same request, single item streams
    write_thresholds(16'd16, 16'd1);
    drive_item(16'd40, 1'b0);
    drive_item(16'd30, 1'b0);
    drive_item(16'd35, 1'b1);
    drive_item(16'd0, 1'b1);
    drive_item(16'hFFFF, 1'b1);
    drive_item(16'd15, 1'b0);
    drive_item(16'd16, 1'b0);
    drive_item(16'd16, 1'b0);
    drive_item(16'd15, 1'b1);

    write_thresholds(16'd16, 16'd1);
    hold_long = 1'b1;
    run_streams(PHASE_ITEMS);
    write_thresholds(16'd0, 16'd0);
    run_streams(PHASE_ITEMS);
    write_thresholds(16'hFFFF, 16'd1);
    run_streams(PHASE_ITEMS);
    write_thresholds(16'd40, 16'd3);
    run_streams(PHASE_ITEMS);
    write_thresholds(lcpc_pkg::CFG_BITS'($urandom_range(0, 65535)),
                     lcpc_pkg::CFG_BITS'($urandom_range(0, 5)));
    run_streams(PHASE_ITEMS);
    write_thresholds(16'd1000, 16'hFFFF);
    run_streams(PHASE_ITEMS);

    write_thresholds(lcpc_pkg::CFG_BITS'($urandom_range(0, 65535)),
                     lcpc_pkg::CFG_BITS'($urandom_range(0, 5)));
    idle_on = 1'b1;
    run_streams(PHASE_ITEMS);
    write_thresholds(16'd20, 16'd2);
    idle_on = 1'b0;
    run_streams(PHASE_ITEMS);
    in_if.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d requests in %0d streams under %0d threshold settings",
             tracker.requests, tracker.streams, settings + 1);
    $display("%0d clusters checked, %0d dropped as short, %0d requests closed and flushed",
             tracker.checked, tracker.dropped, tracker.doubles);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
